// ===== rtl/prtme_pkg.sv =====
// package: widths, datapath commands and status for the modexp unit
`default_nettype none
package prtme_pkg;
  localparam int unsigned Width = 16;
  localparam int unsigned CntW  = 5;
  localparam logic [Width-1:0] ModReset = Width'(2);

  typedef enum logic [2:0] {
    MOD_B   = 3'd0,  // b = b mod m
    MUL_ACC = 3'd1,  // acc = acc*b mod m
    MUL_SQR = 3'd2,  // b = b*b mod m
    MUL_P   = 3'd3   // acc = acc*b mod m (root test power)
  } mul_op_e;

  typedef struct packed {
    logic           load;   // load operands, init acc
    logic           start;  // start a modular operation
    mul_op_e        op;
    logic           shift;  // next exponent bit
    logic           inc;    // root test index increment
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic ebit;
    logic bit_last;
    logic acc_one;
    logic idx_end;   // i + 1 >= m
    logic opcode;
    logic mod_zero;
    logic exp_zero;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/primitive_root_test_modexp_unit.sv =====
// top level: modexp and primitive root test unit with output register
//
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata[15:0] base, [31:16] exponent; tuser opcode
// m_axis    out  m_axis_tvalid/tready   tdata[15:0] value; tuser error
// cfg       in   cfg_valid_i/ready_o    cfg_data_i modulus
//
// each modular operation is 32 bit-serial restoring steps; exponentiation reduces the base once, then
// squares for every exponent bit and multiplies first for each set bit; the root test takes
// one power per index, up to m-2 indexes.
// one item at a time; the next is taken once the result moved to the output register.
// reset sets the modulus to 2 and empties the output register; no clearing pass.
`default_nettype none
module primitive_root_test_modexp_unit import prtme_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // base, exponent
  input  wire logic [0:0]  s_axis_tuser,   // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // value
  output logic [0:0]       m_axis_tuser,   // error
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  logic [Width-1:0] mod_q, val, val_q;
  logic err, err_q, ovalid_q, idle, done, in_fire;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [Width-1:0] acc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mod_q <= ModReset;
    else if (cfg_valid_i) mod_q <= cfg_data_i;
  end

  prtme_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .opcode_i(s_axis_tuser[0]),
    .base_i(s_axis_tdata[15:0]), .exponent_i(s_axis_tdata[31:16]),
    .modulus_i(mod_q), .sts_o(sts), .acc_o(acc)
  );

  prtme_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire),
    .out_free_i(!ovalid_q || m_axis_tready), .sts_i(sts), .acc_i(acc),
    .cmd_o(cmd), .idle_o(idle), .done_o(done), .value_o(val), .error_o(err)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (done) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) begin
      val_q <= val;
      err_q <= err;
    end
  end

  assign m_axis_tvalid   = ovalid_q;
  assign m_axis_tdata    = val_q;
  assign m_axis_tuser[0] = err_q;
endmodule
`default_nettype wire

// ===== rtl/prtme_datapath.sv =====
// datapath: operand registers, multiplier and bit-serial modulo reduction
`default_nettype none
module prtme_datapath import prtme_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  input  wire logic             opcode_i,
  input  wire logic [Width-1:0] base_i,
  input  wire logic [Width-1:0] exponent_i,
  input  wire logic [Width-1:0] modulus_i,
  output dp_sts_t               sts_o,
  output logic      [Width-1:0] acc_o
);
  localparam int unsigned PW = 2 * Width;
  localparam int unsigned RemW = Width + 1;

  logic [Width-1:0] m_q, b_q, e_q, acc_q, idx_q;
  logic             op_q, ez_q;
  logic [CntW-1:0]  bcnt_q;
  // reduction state
  logic [PW-1:0]    num_q;
  logic [Width-1:0] rem_q;
  logic [CntW:0]    rcnt_q;
  logic             busy_q;
  mul_op_e          rop_q;
  logic [PW-1:0]    prod;
  logic [RemW-1:0]  trial;
  logic [RemW-1:0]  rnext;

  // product select: b alone, b*b or acc*b
  always_comb begin
    unique case (cmd_i.op)
      MOD_B:   prod = {{Width{1'b0}}, b_q};
      MUL_SQR: prod = b_q * b_q;
      default: prod = acc_q * b_q;
    endcase
  end

  // restoring remainder step, one numerator bit a cycle
  assign trial = {rem_q, num_q[PW-1]};
  assign rnext = (trial >= {1'b0, m_q}) ? trial - {1'b0, m_q} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rcnt_q <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      rcnt_q <= (CntW+1)'(PW);
    end else if (busy_q) begin
      rcnt_q <= rcnt_q - 1'b1;
      if (rcnt_q == (CntW+1)'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q    <= modulus_i;
      b_q    <= base_i;
      e_q    <= exponent_i;
      ez_q   <= (exponent_i == '0);
      op_q   <= opcode_i;
      acc_q  <= Width'(1);
      bcnt_q <= '0;
      idx_q  <= Width'(1);
    end else begin
      if (cmd_i.start) begin
        num_q <= prod;
        rem_q <= '0;
        rop_q <= cmd_i.op;
      end else if (busy_q) begin
        num_q <= {num_q[PW-2:0], 1'b0};
        rem_q <= rnext[Width-1:0];
        if (rcnt_q == (CntW+1)'(1)) begin
          if (rop_q == MOD_B || rop_q == MUL_SQR) b_q <= rnext[Width-1:0];
          else acc_q <= rnext[Width-1:0];
        end
      end
      if (cmd_i.shift) begin
        e_q    <= e_q >> 1;
        bcnt_q <= bcnt_q + 1'b1;
      end
      if (cmd_i.inc) idx_q <= idx_q + 1'b1;
    end
  end

  assign sts_o.busy     = busy_q;
  assign sts_o.ebit     = e_q[0];
  assign sts_o.bit_last = (bcnt_q == CntW'(Width - 1));
  assign sts_o.acc_one  = (acc_q == Width'(1));
  assign sts_o.idx_end  = ({1'b0, idx_q} + 1'b1) >= {1'b0, m_q};
  assign sts_o.opcode   = op_q;
  assign sts_o.mod_zero = (m_q == '0);
  assign sts_o.exp_zero = ez_q;
  assign acc_o          = acc_q;
endmodule
`default_nettype wire

// ===== rtl/prtme_ctrl.sv =====
// controller: sequences square-and-multiply and the root test loop
`default_nettype none
module prtme_ctrl import prtme_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_fire_i,
  input  wire logic             out_free_i,
  input  wire dp_sts_t          sts_i,
  input  wire logic [Width-1:0] acc_i,
  output dp_cmd_t               cmd_o,
  output logic                  idle_o,
  output logic                  done_o,
  output logic      [Width-1:0] value_o,
  output logic                  error_o
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DISP = 8'b00000010,
    S_RB   = 8'b00000100,
    S_BIT  = 8'b00001000,
    S_WM   = 8'b00010000,
    S_WS   = 8'b00100000,
    S_WP   = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [Width-1:0] val_q, val_d;
  logic err_q, err_d;
  logic wait_q, wait_d;  // masks the busy check in the cycle after a start

  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    err_d   = err_q;
    wait_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.op = MOD_B;
    unique case (state_q)
      S_IDLE: if (in_fire_i) begin
        cmd_o.load = 1'b1;
        state_d    = S_DISP;
      end
      S_DISP: begin
        if (sts_i.mod_zero) begin
          val_d = '0; err_d = 1'b1; state_d = S_OUT;
        end else if (sts_i.opcode && sts_i.idx_end) begin
          val_d = Width'(1); err_d = 1'b0; state_d = S_OUT;
        end else begin
          err_d = 1'b0;
          cmd_o.start = 1'b1; cmd_o.op = MOD_B; wait_d = 1'b1;
          state_d = S_RB;
        end
      end
      // root test: stop once the index reaches m-1, else next power; modexp goes on to the exponent bits
      S_RB: if (!wait_q && !sts_i.busy) begin
        if (sts_i.opcode && sts_i.idx_end) begin
          val_d = Width'(1); state_d = S_OUT;
        end else if (sts_i.opcode) begin
          cmd_o.start = 1'b1; cmd_o.op = MUL_P; wait_d = 1'b1; state_d = S_WP;
        end else state_d = S_BIT;
      end
      S_BIT: begin
        if (sts_i.ebit) begin
          cmd_o.start = 1'b1; cmd_o.op = MUL_ACC; wait_d = 1'b1; state_d = S_WM;
        end else begin
          cmd_o.start = 1'b1; cmd_o.op = MUL_SQR; wait_d = 1'b1; state_d = S_WS;
        end
      end
      S_WM: if (!wait_q && !sts_i.busy) begin
        cmd_o.start = 1'b1; cmd_o.op = MUL_SQR; wait_d = 1'b1; state_d = S_WS;
      end
      S_WS: if (!wait_q && !sts_i.busy) begin
        if (sts_i.bit_last) begin
          val_d = sts_i.exp_zero ? Width'(1) : acc_i; state_d = S_OUT;
        end else begin
          cmd_o.shift = 1'b1; state_d = S_BIT;
        end
      end
      S_WP: if (!wait_q && !sts_i.busy) begin
        if (sts_i.acc_one) begin
          val_d = '0; state_d = S_OUT;
        end else begin
          cmd_o.inc = 1'b1; state_d = S_RB;
        end
      end
      S_OUT: if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    err_q <= err_d;
  end

  assign idle_o  = (state_q == S_IDLE);
  assign done_o  = (state_q == S_OUT) && out_free_i;
  assign value_o = val_q;
  assign error_o = err_q;

  // an item is only loaded while idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE) else $error("load outside idle");
  // no new reduction while one runs
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> !sts_i.busy) else $error("reduction restarted");
  // error result always carries zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && err_q) |-> val_q == '0) else $error("error with value");
endmodule
`default_nettype wire
